@@ src/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texture sampler
// Field widths, register codes, command codes and the request tag record.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int IDX_W      = 14;
  localparam int WORD_W     = 16;
  localparam int COORD_W    = 24;
  localparam int SIDE_REG_W = 9;
  localparam int CHAN_W     = 3;
  localparam int FRAC_W     = 16;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int REM_STEP   = 6;

  localparam int DEF_STORE_WORDS = 16384;
  localparam int DEF_MAX_SIDE    = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CHAN   = 2'd2,
    REG_BILIN  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] val;
    logic [FRAC_W-1:0] fa;
    logic [FRAC_W-1:0] fb;
  } bts_tag_t;

endpackage

@@ src/bilinear_texture_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit: pipelined nearest / bilinear texture sampler
// A sample request makes R texel word reads and a write request one store
// write, where R = texels (1 or 4) times words per texel (0-3). New requests
// can enter the earlier stages while a sample is still reading the store.
// Reset clears all valid bits and the configuration registers; the store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit #(
  parameter int STORE_WORDS = bts_pkg::DEF_STORE_WORDS,
  parameter int MAX_SIDE    = bts_pkg::DEF_MAX_SIDE
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]           cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [bts_pkg::IDX_W-1:0]           word_index,
  input  logic [bts_pkg::WORD_W-1:0]          word_value,
  input  logic signed [bts_pkg::COORD_W-1:0]  coord_u,
  input  logic signed [bts_pkg::COORD_W-1:0]  coord_v,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bts_pkg::WORD_W-1:0]          red,
  output logic [bts_pkg::WORD_W-1:0]          green,
  output logic [bts_pkg::WORD_W-1:0]          blue
);
  import bts_pkg::*;

  // Pipeline overview. Every request, write or sample, runs down the same
  // stages up to F, so that store writes and reads stay in request order:
  //   s1   input register
  //   s2   coordinate scaling, u*width and v*height
  //   rm0  floor or truncation, fractional weights, magnitudes of the four
  //        integer coordinates (x0, x0+1, y0, y0+1)
  //   rm1..rmNS  restoring remainder by the side, REM_STEP bits per stage
  //   pos  texel position y*width+x for the four corner texels
  //   base word address channels*pos
  //   F    fetch sequencer: one store access per cycle (a write, or the
  //        texel word reads of one sample)
  //   B1   horizontal blend of the top and bottom rows
  //   B2   vertical blend, output register
  // Nearest mode runs through the same blend with zero weights, which
  // returns the first texel unchanged.

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PROD_W = COORD_W + SIDE_W + 1;
  localparam int MAG_W  = PROD_W - FRAC_W;
  localparam int NS     = (MAG_W + REM_STEP - 1) / REM_STEP;
  localparam int PAD_W  = NS * REM_STEP;
  localparam int POS_W  = 2 * SIDE_W;
  localparam int BASE_W = POS_W + CHAN_W;
  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int MAX_AW = (BASE_W > ADDR_W) ? BASE_W : ADDR_W;
  localparam int CMP_W  = ((MAX_AW > IDX_W) ? MAX_AW : IDX_W) + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SIDE_REG_W-1:0] tex_width;
  logic [SIDE_REG_W-1:0] tex_height;
  logic [CHAN_W-1:0]     chan_count;
  logic                  bilinear_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= SIDE_REG_W'(1);
      tex_height  <= SIDE_REG_W'(1);
      chan_count  <= CHAN_W'(1);
      bilinear_on <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_WIDTH:  tex_width   <= cfg_data[SIDE_REG_W-1:0];
        REG_HEIGHT: tex_height  <= cfg_data[SIDE_REG_W-1:0];
        REG_CHAN:   chan_count  <= cfg_data[CHAN_W-1:0];
        REG_BILIN:  bilinear_on <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Effective sides: zero is taken as one, anything above MAX_SIDE is clamped.
  logic [SIDE_W-1:0] ws;
  logic [SIDE_W-1:0] hs;

  always_comb begin
    if (tex_width == '0) begin
      ws = SIDE_W'(1);
    end else if (32'(tex_width) > MAX_SIDE) begin
      ws = SIDE_W'(MAX_SIDE);
    end else begin
      ws = SIDE_W'(tex_width);
    end
    if (tex_height == '0) begin
      hs = SIDE_W'(1);
    end else if (32'(tex_height) > MAX_SIDE) begin
      hs = SIDE_W'(MAX_SIDE);
    end else begin
      hs = SIDE_W'(tex_height);
    end
  end

  // Words read per texel: none, one copied to all three colors, two, or three.
  logic [1:0] nrd;

  always_comb begin
    if (chan_count >= CHAN_W'(3)) begin
      nrd = 2'd3;
    end else begin
      nrd = chan_count[1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain. Each stage takes new data when it is empty or when the
  // stage after it takes its current content.
  // --------------------------------------------------------------------------
  logic s1_v, s2_v, pos_v, base_v, f_valid, b1_v;
  logic s1_ready, s2_ready, pos_ready, base_ready, f_ready, b1_ready, b2_ready;
  logic rm_v     [NS+1];
  logic rm_ready [NS+1];
  logic f_leave;

  assign b2_ready   = !out_valid || !out_stall;
  assign b1_ready   = !b1_v || b2_ready;
  assign f_ready    = !f_valid || f_leave;
  assign base_ready = !base_v || f_ready;
  assign pos_ready  = !pos_v || base_ready;

  always_comb begin
    rm_ready[NS] = !rm_v[NS] || pos_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rm_ready[k] = !rm_v[k] || rm_ready[k+1];
    end
  end

  assign s2_ready = !s2_v || rm_ready[0];
  assign s1_ready = !s1_v || s2_ready;
  assign in_stall = !s1_ready;

  // --------------------------------------------------------------------------
  // s1: input register
  // --------------------------------------------------------------------------
  bts_tag_t                   s1_tag;
  logic signed [COORD_W-1:0]  s1_u;
  logic signed [COORD_W-1:0]  s1_v_crd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_ready) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_tag.cmd <= cmd_e'(cmd);
      s1_tag.idx <= word_index;
      s1_tag.val <= word_value;
      s1_tag.fa  <= '0;
      s1_tag.fb  <= '0;
      s1_u       <= coord_u;
      s1_v_crd   <= coord_v;
    end
  end

  // --------------------------------------------------------------------------
  // s2: scale by the effective sides, giving x and y in Q.16
  // --------------------------------------------------------------------------
  bts_tag_t                  s2_tag;
  logic signed [PROD_W-1:0]  s2_xq;
  logic signed [PROD_W-1:0]  s2_yq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_ready) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_tag <= s1_tag;
      s2_xq  <= s1_u * $signed({1'b0, ws});
      s2_yq  <= s1_v_crd * $signed({1'b0, hs});
    end
  end

  // --------------------------------------------------------------------------
  // rm0: integer parts and their magnitudes. The wrap is |c rem side|, which
  // equals |c| mod side, so only magnitudes go on to the remainder stages.
  // Returns {|c+1|, |c|} for bilinear mode and {|c|, |c|} for nearest mode.
  // --------------------------------------------------------------------------
  function automatic logic [2*MAG_W-1:0] axis_mag(input logic signed [PROD_W-1:0] q,
                                                   input logic bil);
    logic [PROD_W-1:0]        aq;
    logic signed [MAG_W-1:0]  c0;
    logic signed [MAG_W:0]    c1;
    logic [MAG_W-1:0]         m0;
    logic [MAG_W-1:0]         m1;
    aq = q[PROD_W-1] ? PROD_W'(-q) : PROD_W'(q);
    c0 = q[PROD_W-1:FRAC_W];
    c1 = {c0[MAG_W-1], c0} + (MAG_W+1)'(1);
    if (bil) begin
      m0 = c0[MAG_W-1] ? MAG_W'(-c0) : MAG_W'(c0);
      m1 = c1[MAG_W]   ? MAG_W'(-c1) : MAG_W'(c1);
    end else begin
      m0 = aq[PROD_W-1:FRAC_W];
      m1 = m0;
    end
    return {m1, m0};
  endfunction

  bts_tag_t          rm_tag [NS+1];
  logic [MAG_W-1:0]  rm_m   [NS+1][4];
  logic [SIDE_W-1:0] rm_r   [NS+1][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      rm_v[0] <= 1'b0;
    end else if (rm_ready[0]) begin
      rm_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rm_ready[0]) begin
      rm_tag[0].cmd <= s2_tag.cmd;
      rm_tag[0].idx <= s2_tag.idx;
      rm_tag[0].val <= s2_tag.val;
      rm_tag[0].fa  <= bilinear_on ? s2_xq[FRAC_W-1:0] : FRAC_W'(0);
      rm_tag[0].fb  <= bilinear_on ? s2_yq[FRAC_W-1:0] : FRAC_W'(0);
      {rm_m[0][1], rm_m[0][0]} <= axis_mag(s2_xq, bilinear_on);
      {rm_m[0][3], rm_m[0][2]} <= axis_mag(s2_yq, bilinear_on);
      for (int l = 0; l < 4; l++) begin
        rm_r[0][l] <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // rm1..rmNS: restoring remainder, REM_STEP magnitude bits per stage.
  // Lanes 0 and 1 divide by the width, lanes 2 and 3 by the height.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NS; k++) begin : g_rem
    logic [SIDE_W-1:0] r_next [4];

    always_comb begin
      logic [PAD_W-1:0]  mp;
      logic [SIDE_W:0]   t;
      logic [SIDE_W-1:0] sd;
      for (int l = 0; l < 4; l++) begin
        mp = PAD_W'(rm_m[k][l]);
        sd = (l < 2) ? ws : hs;
        r_next[l] = rm_r[k][l];
        for (int j = 0; j < REM_STEP; j++) begin
          t = {r_next[l], mp[PAD_W-1-k*REM_STEP-j]};
          if (t >= {1'b0, sd}) begin
            t = t - {1'b0, sd};
          end
          r_next[l] = t[SIDE_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rm_v[k+1] <= 1'b0;
      end else if (rm_ready[k+1]) begin
        rm_v[k+1] <= rm_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rm_ready[k+1]) begin
        rm_tag[k+1] <= rm_tag[k];
        for (int l = 0; l < 4; l++) begin
          rm_m[k+1][l] <= rm_m[k][l];
          rm_r[k+1][l] <= r_next[l];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // pos: texel positions. Corner t uses x lane t[0] and y lane 2 + t[1].
  // --------------------------------------------------------------------------
  bts_tag_t          pos_tag;
  logic [POS_W-1:0]  pos_p [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_v <= 1'b0;
    end else if (pos_ready) begin
      pos_v <= rm_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_ready) begin
      pos_tag <= rm_tag[NS];
      for (int t = 0; t < 4; t++) begin
        pos_p[t] <= POS_W'(rm_r[NS][2 + t/2]) * POS_W'(ws) + POS_W'(rm_r[NS][t%2]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // base: first store word of each corner texel
  // --------------------------------------------------------------------------
  bts_tag_t          base_tag;
  logic [BASE_W-1:0] base_a [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_v <= 1'b0;
    end else if (base_ready) begin
      base_v <= pos_v;
    end
  end

  always_ff @(posedge clk) begin
    if (base_ready) begin
      base_tag <= pos_tag;
      for (int t = 0; t < 4; t++) begin
        base_a[t] <= BASE_W'(pos_p[t]) * BASE_W'(chan_count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // F: fetch sequencer and texel store. A write leaves as its store write
  // is made. A sample issues one read a cycle, walking the words of each
  // corner texel; read data is registered in mem_q, then stored in f_t.
  // --------------------------------------------------------------------------
  bts_tag_t          f_tag;
  logic [BASE_W-1:0] f_base [4];
  logic [1:0]        f_tex;
  logic [1:0]        f_c;
  logic [1:0]        f_last_tex;
  logic [1:0]        f_nrd;
  logic              f_all;
  logic [WORD_W-1:0] f_t [4][3];

  logic              rd_pend;
  logic [1:0]        rd_tex;
  logic [1:0]        rd_c;
  logic              rd_oob;

  logic              f_load;
  logic              do_rd;
  logic              b1_load;
  logic [CMP_W-1:0]  rd_addr;
  logic              rd_addr_oob;
  logic              mem_we;

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] mem_q;

  assign f_load      = base_v && f_ready;
  assign do_rd       = f_valid && (f_tag.cmd == CMD_SAMPLE) && !f_all;
  assign b1_load     = f_valid && (f_tag.cmd == CMD_SAMPLE) && f_all && !rd_pend && b1_ready;
  assign f_leave     = f_valid && ((f_tag.cmd == CMD_WRITE) || b1_load);
  assign rd_addr     = CMP_W'(f_base[f_tex]) + CMP_W'(f_c);
  assign rd_addr_oob = rd_addr >= CMP_W'(STORE_WORDS);
  assign mem_we      = f_valid && (f_tag.cmd == CMD_WRITE) &&
                       (CMP_W'(f_tag.idx) < CMP_W'(STORE_WORDS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(f_tag.idx)] <= f_tag.val;
    end
    mem_q <= mem[rd_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= do_rd;
      if (f_load) begin
        f_valid <= 1'b1;
      end else if (f_leave) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tex <= f_tex;
    rd_c   <= f_c;
    rd_oob <= rd_addr_oob;
    if (f_load) begin
      f_tag      <= base_tag;
      f_tex      <= 2'd0;
      f_c        <= 2'd0;
      f_nrd      <= nrd;
      f_last_tex <= bilinear_on ? 2'd3 : 2'd0;
      f_all      <= (nrd == 2'd0);
      for (int t = 0; t < 4; t++) begin
        f_base[t] <= base_a[t];
        for (int c = 0; c < 3; c++) begin
          f_t[t][c] <= '0;
        end
      end
    end else begin
      if (do_rd) begin
        if (f_c == f_nrd - 2'd1) begin
          f_c <= 2'd0;
          if (f_tex == f_last_tex) begin
            f_all <= 1'b1;
          end else begin
            f_tex <= f_tex + 2'd1;
          end
        end else begin
          f_c <= f_c + 2'd1;
        end
      end
      if (rd_pend) begin
        // A single-channel texel feeds all three colors.
        if (f_nrd == 2'd1) begin
          for (int c = 0; c < 3; c++) begin
            f_t[rd_tex][c] <= rd_oob ? WORD_W'(0) : mem_q;
          end
        end else begin
          f_t[rd_tex][rd_c] <= rd_oob ? WORD_W'(0) : mem_q;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // B1 / B2: linear blends, (p*(1-w) + q*w) truncated to Q8.8
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] blend(input logic [WORD_W-1:0] p,
                                              input logic [WORD_W-1:0] q,
                                              input logic [FRAC_W-1:0] w);
    logic [FRAC_W:0]         iw;
    logic [WORD_W+FRAC_W+1:0] s;
    iw = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, w};
    s  = (WORD_W+FRAC_W+2)'(p) * (WORD_W+FRAC_W+2)'(iw) +
         (WORD_W+FRAC_W+2)'(q) * (WORD_W+FRAC_W+2)'(w);
    return s[WORD_W+FRAC_W-1:FRAC_W];
  endfunction

  logic [WORD_W-1:0] b1_top [3];
  logic [WORD_W-1:0] b1_bot [3];
  logic [FRAC_W-1:0] b1_fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (b1_ready) begin
      b1_v <= b1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready) begin
      b1_fb <= f_tag.fb;
      for (int c = 0; c < 3; c++) begin
        b1_top[c] <= blend(f_t[0][c], f_t[1][c], f_tag.fa);
        b1_bot[c] <= blend(f_t[2][c], f_t[3][c], f_tag.fa);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b2_ready) begin
      out_valid <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_ready) begin
      red   <= blend(b1_top[0], b1_bot[0], b1_fb);
      green <= blend(b1_top[1], b1_bot[1], b1_fb);
      blue  <= blend(b1_top[2], b1_bot[2], b1_fb);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Read data only ever arrives for a sample that is still in the sequencer.
  a_rd_owner: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (f_valid && (f_tag.cmd == CMD_SAMPLE)))
    else $error("texel read returned with no sample in the sequencer");

  // A write request makes its store write and causes no texel read.
  a_wr_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (f_valid && (f_tag.cmd == CMD_WRITE)) |=> !rd_pend)
    else $error("write request caused a texel read");

  // A new result is always preceded by a filled blend stage.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b1_v))
    else $error("result appeared without a blended sample");

  // The sequencer never hands a sample on while a read is still in flight.
  a_no_early_leave: assert property (@(posedge clk) disable iff (rst)
    b1_load |-> !rd_pend)
    else $error("sample left the sequencer before its last texel word");

endmodule
